// File: rtl/vge_pkg.sv
package vge_pkg;

	// Width of each coordinate field of a result.
	localparam int POS_BITS = 6;

	// Configuration port.
	localparam int CFG_DATA_BITS = 7;
	localparam int CFG_ADDR_BITS = 2;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_VOL_WIDTH  = 2'd0,
		REG_VOL_HEIGHT = 2'd1,
		REG_VOL_DEPTH  = 2'd2
	} cfg_reg_t;

	// Side information that travels down the pipeline with each result.
	typedef struct packed {
		logic [POS_BITS-1:0] pos_x;
		logic [POS_BITS-1:0] pos_y;
		logic [POS_BITS-1:0] pos_z;
		logic                final_voxel;
		logic                interior;
	} res_tag_t;

endpackage

// File: rtl/volume_gradient_energy.sv
// Each result is registered in stages s1, s2, s3 and s4 between an input transfer and the master side.
// Throughput: one voxel or flush transfer per cycle while s_tready is high; each stage stalls only when
// the stage after it is full, so bubbles are squeezed out during a stall.
// Three copies of a two-plane voxel memory (read data registered) serve the stencil.
// Reset clears the counters, valid bits and dimension registers (to 64 or the
// maximum, whichever is smaller); the voxel memories are not cleared.
module volume_gradient_energy #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_DEPTH  = 64,
	parameter int VOXEL_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wen,
	input  logic [vge_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
	input  logic [vge_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// voxel
	input  logic [((VOXEL_BITS+7)/8)*8-1:0]        s_tdata,
	// cmd
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// energy, pos_x, pos_y, pos_z
	output logic [((2*VOXEL_BITS+2+3*vge_pkg::POS_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                   m_tlast
);
	import vge_pkg::*;

	localparam int XB = $clog2(MAX_WIDTH);
	localparam int YB = $clog2(MAX_HEIGHT);
	localparam int AW = 1 + YB + XB;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int ZW = $clog2(MAX_DEPTH + 1);
	localparam int EB = 2 * VOXEL_BITS + 2;
	localparam int SB = 2 * VOXEL_BITS;
	localparam int OUT_BITS = ((EB + 3 * POS_BITS + 7) / 8) * 8;
	localparam int W_RST = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
	localparam int H_RST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
	localparam int D_RST = (MAX_DEPTH < 64) ? MAX_DEPTH : 64;
	localparam int DEPTH = 1 << AW;

	function automatic int clamp_dim(input logic [CFG_DATA_BITS-1:0] v, input int maxv);
		int r;
		r = int'(v);
		if (r < 1) r = 1;
		if (r > maxv) r = maxv;
		return r;
	endfunction

	// Dimensions and stream position.
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [ZW-1:0] d_q;
	logic [XB-1:0] in_x_q, fl_x_q;
	logic [YB-1:0] in_y_q, fl_y_q;
	logic [ZW-1:0] in_z_q;

	logic cfg_hit;
	logic acc, is_flush, vox_ok, fl_ok, emit, fl_last, interior;
	logic [XB:0] x_inc, fx_inc;
	logic [YB:0] y_inc, fy_inc;
	logic [XB-1:0] xm1, xp1;
	logic [YB-1:0] ym1, yp1;
	logic [ZW-1:0] zm1, dm1;
	logic [VOXEL_BITS-1:0] vox;
	logic [AW-1:0] wr_addr;
	res_tag_t tag_in;

	// Pipeline enables, from the output backwards.
	logic en1, en2, en3, en4;
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	res_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	// Voxel memories: A gives the x neighbors, B the y neighbors, C the plane two back.
	logic [VOXEL_BITS-1:0] mem_a [DEPTH];
	logic [VOXEL_BITS-1:0] mem_b [DEPTH];
	logic [VOXEL_BITS-1:0] mem_c [DEPTH];
	logic [VOXEL_BITS-1:0] xl_s1, xr_s1, yu_s1, yd_s1, zb_s1, vox_s1;
	logic [VOXEL_BITS-1:0] dx_s2, dy_s2, dz_s2;
	logic [SB-1:0] sx_s3, sy_s3, sz_s3;
	logic [EB-1:0] energy_s4;

	assign en4 = !v4_s4 || m_tready;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign s_tready = en1;

	assign cfg_hit = cfg_wen && (cfg_addr == REG_VOL_WIDTH || cfg_addr == REG_VOL_HEIGHT
		|| cfg_addr == REG_VOL_DEPTH);

	always_comb begin
		acc      = s_tvalid && s_tready;
		is_flush = s_tuser;
		vox      = s_tdata[VOXEL_BITS-1:0];
		vox_ok   = !is_flush && (in_z_q < d_q);
		fl_ok    = is_flush && (in_z_q >= d_q);
		emit     = (vox_ok && (in_z_q != '0)) || fl_ok;
		x_inc    = {1'b0, in_x_q} + (XB+1)'(1);
		y_inc    = {1'b0, in_y_q} + (YB+1)'(1);
		fx_inc   = {1'b0, fl_x_q} + (XB+1)'(1);
		fy_inc   = {1'b0, fl_y_q} + (YB+1)'(1);
		fl_last  = (fx_inc >= (XB+1)'(w_q)) && (fy_inc >= (YB+1)'(h_q));
		xm1      = in_x_q - XB'(1);
		xp1      = in_x_q + XB'(1);
		ym1      = in_y_q - YB'(1);
		yp1      = in_y_q + YB'(1);
		zm1      = in_z_q - ZW'(1);
		dm1      = d_q - ZW'(1);
		interior = vox_ok && (in_z_q > ZW'(1)) && (in_x_q != '0) && (x_inc < (XB+1)'(w_q))
			&& (in_y_q != '0) && (y_inc < (YB+1)'(h_q));
		wr_addr  = {in_z_q[0], in_y_q, in_x_q};
		if (is_flush) begin
			tag_in.pos_x       = POS_BITS'(fl_x_q);
			tag_in.pos_y       = POS_BITS'(fl_y_q);
			tag_in.pos_z       = POS_BITS'(dm1);
			tag_in.final_voxel = fl_last;
		end else begin
			tag_in.pos_x       = POS_BITS'(in_x_q);
			tag_in.pos_y       = POS_BITS'(in_y_q);
			tag_in.pos_z       = POS_BITS'(zm1);
			tag_in.final_voxel = 1'b0;
		end
		tag_in.interior = interior;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WW'(W_RST);
			h_q    <= HW'(H_RST);
			d_q    <= ZW'(D_RST);
			in_x_q <= '0;
			in_y_q <= '0;
			in_z_q <= '0;
			fl_x_q <= '0;
			fl_y_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_reg_t'(cfg_addr))
				REG_VOL_WIDTH:  w_q <= WW'(clamp_dim(cfg_wdata, MAX_WIDTH));
				REG_VOL_HEIGHT: h_q <= HW'(clamp_dim(cfg_wdata, MAX_HEIGHT));
				REG_VOL_DEPTH:  d_q <= ZW'(clamp_dim(cfg_wdata, MAX_DEPTH));
				default: ;
			endcase
			in_x_q <= '0;
			in_y_q <= '0;
			in_z_q <= '0;
			fl_x_q <= '0;
			fl_y_q <= '0;
		end else if (acc && vox_ok) begin
			if (x_inc >= (XB+1)'(w_q)) begin
				in_x_q <= '0;
				if (y_inc >= (YB+1)'(h_q)) begin
					in_y_q <= '0;
					in_z_q <= in_z_q + ZW'(1);
				end else begin
					in_y_q <= y_inc[YB-1:0];
				end
			end else begin
				in_x_q <= x_inc[XB-1:0];
			end
		end else if (acc && fl_ok) begin
			if (fl_last) begin
				// The volume is done; the next voxel starts a new one.
				in_x_q <= '0;
				in_y_q <= '0;
				in_z_q <= '0;
				fl_x_q <= '0;
				fl_y_q <= '0;
			end else if (fx_inc >= (XB+1)'(w_q)) begin
				fl_x_q <= '0;
				fl_y_q <= fy_inc[YB-1:0];
			end else begin
				fl_x_q <= fx_inc[XB-1:0];
			end
		end
	end

	// Reads see the contents from before this edge, so memory C returns the
	// plane two back at the very address the current voxel overwrites.
	always_ff @(posedge clk) begin
		if (acc && vox_ok) mem_a[wr_addr] <= vox;
		if (en1) begin
			xl_s1 <= mem_a[{~in_z_q[0], in_y_q, xm1}];
			xr_s1 <= mem_a[{~in_z_q[0], in_y_q, xp1}];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && vox_ok) mem_b[wr_addr] <= vox;
		if (en1) begin
			yu_s1 <= mem_b[{~in_z_q[0], ym1, in_x_q}];
			yd_s1 <= mem_b[{~in_z_q[0], yp1, in_x_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && vox_ok) mem_c[wr_addr] <= vox;
		if (en1) zb_s1 <= mem_c[wr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= acc && emit;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			tag_s1 <= tag_in;
			vox_s1 <= vox;
		end
		if (en2) begin
			tag_s2 <= tag_s1;
			dx_s2  <= (xl_s1 > xr_s1) ? xl_s1 - xr_s1 : xr_s1 - xl_s1;
			dy_s2  <= (yu_s1 > yd_s1) ? yu_s1 - yd_s1 : yd_s1 - yu_s1;
			dz_s2  <= (zb_s1 > vox_s1) ? zb_s1 - vox_s1 : vox_s1 - zb_s1;
		end
		if (en3) begin
			tag_s3 <= tag_s2;
			sx_s3  <= SB'(dx_s2) * SB'(dx_s2);
			sy_s3  <= SB'(dy_s2) * SB'(dy_s2);
			sz_s3  <= SB'(dz_s2) * SB'(dz_s2);
		end
		if (en4) begin
			tag_s4 <= tag_s3;
			// Faces, and every flush result, give zero.
			if (tag_s3.interior) begin
				energy_s4 <= EB'(sx_s3) + EB'(sy_s3) + EB'(sz_s3);
			end else begin
				energy_s4 <= '0;
			end
		end
	end

	assign m_tvalid = v4_s4;
	assign m_tdata  = OUT_BITS'({tag_s4.pos_z, tag_s4.pos_y, tag_s4.pos_x, energy_s4});
	assign m_tlast  = tag_s4.final_voxel;

endmodule

// File: tb/sv/volume_gradient_energy_tb.sv
`timescale 1ns / 100ps

module volume_gradient_energy_tb;
	import vge_pkg::*;

	localparam int MAX_DIM       = 64;
	localparam int PLANE_CELLS   = MAX_DIM * MAX_DIM;
	localparam int SETTLE_CYCLES = 12;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 250;

	// Index past the three registers; the block must ignore it.
	localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 2'd3;

	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_DENSE} rx_mode_t;

	typedef struct {
		logic [33:0]         energy;
		logic [POS_BITS-1:0] pos_x;
		logic [POS_BITS-1:0] pos_y;
		logic [POS_BITS-1:0] pos_z;
		logic                final_voxel;
	} grad_result_t;

	// Tracks the voxel stream and predicts the energy of every voxel.
	class energy_tracker;
		logic [15:0]  planes [0:2*PLANE_CELLS-1];
		int unsigned  cur_x, cur_y, cur_z, flush_count;
		int unsigned  dim_w, dim_h, dim_d;
		grad_result_t awaiting [$];
		int unsigned  errors;

		function new();
			dim_w  = MAX_DIM;
			dim_h  = MAX_DIM;
			dim_d  = MAX_DIM;
			errors = 0;
			restart_stream();
		endfunction

		function void restart_stream();
			cur_x       = 0;
			cur_y       = 0;
			cur_z       = 0;
			flush_count = 0;
		endfunction

		function void write_reg(logic [CFG_ADDR_BITS-1:0] idx,
		                        logic [CFG_DATA_BITS-1:0] val);
			int unsigned dim;
			dim = (val == 0) ? 1 : ((val > MAX_DIM) ? MAX_DIM : val);
			case (idx)
			REG_VOL_WIDTH: dim_w = dim;
			REG_VOL_HEIGHT: dim_h = dim;
			REG_VOL_DEPTH: dim_d = dim;
			default: return;
			endcase
			restart_stream();
		endfunction

		function int unsigned addr_of(int unsigned z, int unsigned y, int unsigned x);
			return (z % 2) * PLANE_CELLS + y * MAX_DIM + x;
		endfunction

		function longint unsigned sq_diff(logic [15:0] a, logic [15:0] b);
			longint unsigned d;
			d = (a > b) ? 64'(a - b) : 64'(b - a);
			return d * d;
		endfunction

		function void take_item(logic flush, logic [15:0] vox);
			grad_result_t    r;
			longint unsigned e;
			int unsigned     zr;
			if (!flush) begin
				if (cur_z >= dim_d)
					return;
				// Each voxel of plane z completes the stencil of the same
				// column one plane back.
				if (cur_z >= 1) begin
					zr = cur_z - 1;
					e  = 0;
					if (zr >= 1 && cur_x >= 1 && cur_x + 1 < dim_w &&
					    cur_y >= 1 && cur_y + 1 < dim_h) begin
						e = sq_diff(planes[addr_of(zr, cur_y, cur_x - 1)],
						            planes[addr_of(zr, cur_y, cur_x + 1)])
						  + sq_diff(planes[addr_of(zr, cur_y - 1, cur_x)],
						            planes[addr_of(zr, cur_y + 1, cur_x)])
						  + sq_diff(planes[addr_of(zr - 1, cur_y, cur_x)], vox);
					end
					r.energy      = e[33:0];
					r.pos_x       = POS_BITS'(cur_x);
					r.pos_y       = POS_BITS'(cur_y);
					r.pos_z       = POS_BITS'(zr);
					r.final_voxel = 1'b0;
					awaiting.insert(awaiting.size(), r);
				end
				planes[addr_of(cur_z, cur_y, cur_x)] = vox;
				cur_x++;
				if (cur_x >= dim_w) begin
					cur_x = 0;
					cur_y++;
					if (cur_y >= dim_h) begin
						cur_y = 0;
						cur_z++;
					end
				end
			end else begin
				if (cur_z < dim_d)
					return;
				r.energy      = '0;
				r.pos_x       = POS_BITS'(flush_count % dim_w);
				r.pos_y       = POS_BITS'(flush_count / dim_w);
				r.pos_z       = POS_BITS'(dim_d - 1);
				r.final_voxel = (flush_count + 1 >= dim_w * dim_h);
				awaiting.insert(awaiting.size(), r);
				if (r.final_voxel)
					restart_stream();
				else
					flush_count++;
			end
		endfunction

		function void compare_field(string field, logic [33:0] want, logic [33:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void match_result(logic [55:0] data, logic last);
			grad_result_t want;
			if (awaiting.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual energy %0d",
				         $time, data[33:0]);
				errors++;
				return;
			end
			want = awaiting.pop_front();
			compare_field("energy", want.energy, data[33:0]);
			compare_field("pos_x", 34'(want.pos_x), 34'(data[39:34]));
			compare_field("pos_y", 34'(want.pos_y), 34'(data[45:40]));
			compare_field("pos_z", 34'(want.pos_z), 34'(data[51:46]));
			compare_field("final_voxel", 34'(want.final_voxel), 34'(last));
		endfunction
	endclass

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_wen   = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	// voxel
	logic [15:0]              s_tdata   = '0;
	// cmd
	logic                     s_tuser   = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	// energy, pos_x, pos_y, pos_z
	logic [55:0]              m_tdata;
	logic                     m_tlast;

	energy_tracker tracker = new();

	int       inputs_taken  = 0;
	int       counted_items = 0;
	int       burst_left    = 0;
	int       cycle_count   = 0;
	int       next_hold_at  = 400;
	int       hold_left     = 0;
	int       rx_left       = 0;
	rx_mode_t rx_mode       = RX_OPEN;

	volume_gradient_energy u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			tracker.take_item(s_tuser, s_tdata);
			inputs_taken <= inputs_taken + 1;
		end
		if (arst_n && m_tvalid && m_tready)
			tracker.match_result(m_tdata, m_tlast);
	end

	// The receiver switches at random between four stall patterns and now and
	// then refuses everything long enough for the block to back up.
	always @(posedge clk) begin
		if (inputs_taken >= next_hold_at) begin
			hold_left = HOLD_CYCLES;
			next_hold_at += 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 80);
			end
			rx_left--;
			case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_HALF: m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("volume_gradient_energy_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [15:0] pick_voxel();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// A 3x3x3 volume whose center sees the full range along every axis.
	function automatic logic [15:0] stencil_value(int unsigned x, int unsigned y, int unsigned z);
		if (x == 1 && y == 1 && z != 1)
			return (z == 0) ? 16'h0000 : 16'hFFFF;
		if (z == 1 && (x == 1) != (y == 1))
			return (x == 0 || y == 0) ? 16'h0000 : 16'hFFFF;
		return 16'(x * 16'h0123 + y * 16'h1230 + z * 16'h2301);
	endfunction

	// Leaves tvalid high after the transfer unless the burst has run out and a random gap is drawn.
	task automatic send_item(input logic flush, input logic [15:0] vox);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= flush;
		s_tdata  <= vox;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 15);
		end
	endtask

	task automatic settle_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.awaiting.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_one(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		tracker.write_reg(idx, val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
	                         input logic [CFG_DATA_BITS-1:0] d);
		settle_results();
		write_one(REG_VOL_WIDTH, w);
		write_one(REG_VOL_HEIGHT, h);
		write_one(REG_VOL_DEPTH, d);
	endtask

	// Streams one volume at the current size; if not cut short, flushes its last plane.
	// Noise adds early flushes and voxels past the end, which must be ignored.
	task automatic stream_volume(input int unsigned stop_after, input bit noisy, input bit directed,
	                             input bit poke);
		int unsigned w, h, d, total, extra;
		int unsigned x, y, z;
		w     = tracker.dim_w;
		h     = tracker.dim_h;
		d     = tracker.dim_d;
		total = w * h * d;
		for (int unsigned i = 0; i < total && i < stop_after; i++) begin
			x = i % w;
			y = (i / w) % h;
			z = i / (w * h);
			// A write to the unused index between planes must not restart the stream.
			if (poke && i == w * h) begin
				settle_results();
				write_one(REG_UNUSED, 7'h7F);
			end
			if (directed ? (i == 4) : (noisy && $urandom_range(0, 29) == 0))
				send_item(1'b1, 16'($urandom));
			send_item(1'b0, directed ? stencil_value(x, y, z) : pick_voxel());
			counted_items++;
		end
		if (stop_after < total)
			return;
		extra = directed ? 2 : (noisy ? $urandom_range(0, 3) : 0);
		repeat (extra) send_item(1'b0, pick_voxel());
		repeat (w * h) begin
			send_item(1'b1, 16'($urandom));
			counted_items++;
		end
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] random_dim();
		case ($urandom_range(0, 15))
		0: return 7'd0;
		1: return CFG_DATA_BITS'($urandom_range(7, 10));
		default: return CFG_DATA_BITS'($urandom_range(1, 5));
		endcase
	endfunction

	initial begin
		int unsigned total, stop_after;
		bit          need_cfg;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset size nothing comes back during the first plane.
		send_item(1'b1, 16'hFFFF);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b0, 16'h8001);

		configure(7'd3, 7'd3, 7'd3);
		stream_volume(27, 1'b0, 1'b1, 1'b1);
		configure(7'd5, 7'd2, 7'd1);
		stream_volume(10, 1'b0, 1'b0, 1'b0);
		configure(7'd0, 7'd127, 7'd2);
		stream_volume(128, 1'b1, 1'b0, 1'b0);
		// Both of these volumes are abandoned partway by the next write.
		configure(7'd127, 7'd3, 7'd3);
		stream_volume(260, 1'b0, 1'b0, 1'b0);
		configure(7'd3, 7'd3, 7'd64);
		stream_volume(120, 1'b1, 1'b0, 1'b0);
		configure(7'd1, 7'd1, 7'd0);
		stream_volume(1, 1'b0, 1'b0, 1'b0);

		need_cfg = 1'b1;
		while (counted_items < 1000) begin
			if (need_cfg || $urandom_range(0, 2) != 0)
				configure(random_dim(), random_dim(), random_dim());
			total      = tracker.dim_w * tracker.dim_h * tracker.dim_d;
			need_cfg   = ($urandom_range(0, 9) == 0);
			stop_after = need_cfg ? $urandom_range(0, total - 1) : total;
			stream_volume(stop_after, $urandom_range(0, 1), 1'b0,
			              tracker.dim_d >= 2 && $urandom_range(0, 11) == 0);
		end

		settle_results();
		if (tracker.errors == 0 && tracker.awaiting.size() == 0)
			$display("volume_gradient_energy_tb: done, clean");
		else
			$display("volume_gradient_energy_tb: done, errors");
		$finish;
	end

endmodule
